// ===== hw/rtl/gzhp_pkg.sv =====
`default_nettype none

package gzhp_pkg;

    // Header byte counter; the length field of a result is always 20 bits wide
    localparam int COUNT_BITS = 20;
    localparam int LEN_W      = 20;
    localparam int CNT_W      = (COUNT_BITS < LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

    localparam logic [7:0] MAGIC0_BYTE = 8'h1f;
    localparam logic [7:0] MAGIC1_BYTE = 8'h8b;
    localparam logic [7:0] METHOD_DEFL = 8'h08;
    localparam logic [7:0] FL_HCRC     = 8'h02;
    localparam logic [7:0] FL_EXTRA    = 8'h04;
    localparam logic [7:0] FL_NAME     = 8'h08;
    localparam logic [7:0] FL_COMMENT  = 8'h10;
    localparam logic [7:0] FL_RESV     = 8'he0;
    localparam logic [CNT_W-1:0] FIXED_LEN = CNT_W'(10);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_MAGIC0  = 4'd1,
        PH_MAGIC1  = 4'd2,
        PH_METHOD  = 4'd3,
        PH_FLAGS   = 4'd4,
        PH_FIXED   = 4'd5,
        PH_XLEN0   = 4'd6,
        PH_XLEN1   = 4'd7,
        PH_XDATA   = 4'd8,
        PH_NAME    = 4'd9,
        PH_COMMENT = 4'd10,
        PH_CRC0    = 4'd11,
        PH_CRC1    = 4'd12,
        PH_DONE    = 4'd13
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MAGIC     = 3'd1,
        ST_METHOD    = 3'd2,
        ST_RESERVED  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_TOOLONG   = 3'd5
    } t_status;

    typedef struct packed {
        t_phase            phase;
        logic [CNT_W-1:0]  byte_count;
        logic [15:0]       extra_rem;
        logic [7:0]        flag_bits;
    } t_parse_state;

    typedef struct packed {
        logic              emit;
        t_status           status;
        logic [LEN_W-1:0]  length;
        logic [7:0]        flags;
    } t_result;

    // First optional section at or after 'from' that the flags call for
    function automatic t_phase next_section(input t_phase from, input logic [7:0] flags);
        t_phase ph;
        ph = PH_DONE;
        priority if (from <= PH_XLEN0 && (flags & FL_EXTRA) != 8'h00) ph = PH_XLEN0;
        else if (from <= PH_NAME && (flags & FL_NAME) != 8'h00)       ph = PH_NAME;
        else if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00) ph = PH_COMMENT;
        else if (from <= PH_CRC0 && (flags & FL_HCRC) != 8'h00)       ph = PH_CRC0;
        else                                                          ph = PH_DONE;
        return ph;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gzhp_step.sv =====
`default_nettype none

module gzhp_step (
    input  wire  gzhp_pkg::t_parse_state i_state,
    input  wire  logic [7:0]             i_byte,
    input  wire  logic                   i_start,
    input  wire  logic                   i_last,
    output       gzhp_pkg::t_parse_state o_state,
    output       gzhp_pkg::t_result      o_result
);
    import gzhp_pkg::*;

    t_parse_state     cur;
    t_parse_state     nxt;
    logic [CNT_W-1:0] cnt1;
    logic [15:0]      ext;
    logic             err;
    t_status          err_code;

    always_comb begin
        cur = i_state;
        if (i_start) begin
            cur.phase      = PH_MAGIC0;
            cur.byte_count = '0;
            cur.extra_rem  = '0;
            cur.flag_bits  = '0;
        end

        nxt      = cur;
        cnt1     = cur.byte_count + CNT_W'(1);
        ext      = '0;
        err      = 1'b0;
        err_code = ST_OK;
        o_result = '{emit: 1'b0, status: ST_OK, length: '0, flags: cur.flag_bits};

        if (cur.phase == PH_IDLE || cur.phase > PH_CRC1) begin
            nxt.phase = PH_IDLE;
        end else if (cur.byte_count >= COUNT_LIMIT) begin
            o_result.emit   = 1'b1;
            o_result.status = ST_TOOLONG;
            nxt.phase       = PH_IDLE;
        end else begin
            nxt.byte_count = cnt1;
            unique case (cur.phase)
                PH_MAGIC0: begin
                    if (i_byte != MAGIC0_BYTE) begin
                        err = 1'b1; err_code = ST_MAGIC;
                    end else nxt.phase = PH_MAGIC1;
                end
                PH_MAGIC1: begin
                    if (i_byte != MAGIC1_BYTE) begin
                        err = 1'b1; err_code = ST_MAGIC;
                    end else nxt.phase = PH_METHOD;
                end
                PH_METHOD: begin
                    if (i_byte != METHOD_DEFL) begin
                        err = 1'b1; err_code = ST_METHOD;
                    end else nxt.phase = PH_FLAGS;
                end
                PH_FLAGS: begin
                    nxt.flag_bits = i_byte;
                    if ((i_byte & FL_RESV) != 8'h00) begin
                        err = 1'b1; err_code = ST_RESERVED;
                    end else nxt.phase = PH_FIXED;
                end
                PH_FIXED: begin
                    if (cnt1 >= FIXED_LEN) nxt.phase = next_section(PH_XLEN0, cur.flag_bits);
                end
                PH_XLEN0: begin
                    nxt.extra_rem = {8'h00, i_byte};
                    nxt.phase     = PH_XLEN1;
                end
                PH_XLEN1: begin
                    ext           = {i_byte, cur.extra_rem[7:0]};
                    nxt.extra_rem = ext;
                    nxt.phase     = (ext != 16'h0000) ? PH_XDATA
                                                      : next_section(PH_NAME, cur.flag_bits);
                end
                PH_XDATA: begin
                    ext           = cur.extra_rem - 16'd1;
                    nxt.extra_rem = ext;
                    if (ext == 16'h0000) nxt.phase = next_section(PH_NAME, cur.flag_bits);
                end
                PH_NAME: begin
                    if (i_byte == 8'h00) nxt.phase = next_section(PH_COMMENT, cur.flag_bits);
                end
                PH_COMMENT: begin
                    if (i_byte == 8'h00) nxt.phase = next_section(PH_CRC0, cur.flag_bits);
                end
                PH_CRC0: nxt.phase = PH_CRC1;
                PH_CRC1: nxt.phase = PH_DONE;
                default: nxt.phase = PH_IDLE;
            endcase

            o_result.flags = nxt.flag_bits;
            // an error on this byte wins over truncation on the same byte
            priority if (err) begin
                o_result.emit   = 1'b1;
                o_result.status = err_code;
                nxt.phase       = PH_IDLE;
            end else if (nxt.phase == PH_DONE) begin
                o_result.emit   = 1'b1;
                o_result.status = ST_OK;
                o_result.length = LEN_W'(cnt1);
                nxt.phase       = PH_IDLE;
            end else if (i_last) begin
                o_result.emit   = 1'b1;
                o_result.status = ST_TRUNCATED;
                nxt.phase       = PH_IDLE;
            end else begin
                o_result.emit   = 1'b0;
            end
        end
        o_state = nxt;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gzip_header_parser_unit.sv =====
`default_nettype none

// gzip member header parser. Bytes of a gzip stream enter on the slave side one
// request per cycle; tuser marks the first byte of a stream (and restarts any parse
// in flight), tlast marks the last byte available. For every started stream not
// restarted mid-header exactly one result leaves on the master side: on the byte
// that completes the header, on the byte that shows an error (bad magic, method
// other than deflate, reserved flag bits set, header longer than 2^20-1 bytes) or
// on the tlast byte if the header is still incomplete there (truncated). A restarted
// parse gives no result. Throughput is one byte per cycle while the master side
// takes results; a byte is held in the input register, then the phase update moves
// its result into the result register. The phase/count update of the parse state is
// the single loop setting the throughput. Bytes with no parse running are swallowed.
module gzip_header_parser_unit (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_s_tvalid,
    output       logic        o_s_tready,
    input  wire  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire  logic        i_s_tuser,   // [0] start_req
    input  wire  logic        i_s_tlast,   // end_of_input
    output       logic        o_m_tvalid,
    input  wire  logic        i_m_tready,
    output       logic [31:0] o_m_tdata    // [2:0] status, [22:3] header_length,
                                           // [30:23] flags_seen, [31] zero
);
    import gzhp_pkg::*;

    // input register stage
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_start;
    logic         r_in_last;

    // parse state and result register
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_result;
    logic         r_out_valid;
    t_status      r_out_status;
    logic [LEN_W-1:0] r_out_len;
    logic [7:0]   r_out_flags;

    logic         out_free;
    logic         consume;

    // the held byte moves on once the result register can take whatever it makes
    assign out_free   = !r_out_valid || i_m_tready;
    assign consume    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || consume;

    gzhp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_start  (r_in_start),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
            r_in_last  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, byte_count: '0, extra_rem: '0, flag_bits: '0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && n_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && n_result.emit) begin
            r_out_status <= n_result.status;
            r_out_len    <= n_result.length;
            r_out_flags  <= n_result.flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_flags, r_out_len, r_out_status};

    // a good header is at least the fixed ten bytes
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OK) |-> (r_out_len >= LEN_W'(10)))
        else $error("ok result with short header length");

    // failed parses carry no length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_len == '0))
        else $error("error result with nonzero length");

    // magic and method errors come before the flag byte is read
    a_early_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_MAGIC || r_out_status == ST_METHOD))
            |-> (r_out_flags == 8'h00))
        else $error("flags reported before flag byte");

    // done is transient: the parser returns to idle on the byte that completes it
    a_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != PH_DONE)
        else $error("parse state held in done");

    // past the first magic byte at least one byte has been counted
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE && r_state.phase != PH_MAGIC0)
            |-> (r_state.byte_count != '0))
        else $error("byte count lost mid-header");

endmodule

`default_nettype wire
